// ===== src/key_scan_midi_note_generator_assert.svh =====
// ----------------------------------------------------------------------------
// key scan midi note generator assertion macros
// shared assertion helpers, clocked on clk, quiet while rst_n is low
// ----------------------------------------------------------------------------
`ifndef KEY_SCAN_MIDI_NOTE_GENERATOR_ASSERT_SVH
`define KEY_SCAN_MIDI_NOTE_GENERATOR_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define KMNG_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// antecedent implies consequent in the next cycle
`define KMNG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/kmng_pkg.sv =====
// ----------------------------------------------------------------------------
// kmng_pkg
// types and constants shared by the key scan midi note generator
// ----------------------------------------------------------------------------
package kmng_pkg;

  localparam int KEYS_PER_ROW_DEF = 16;
  localparam int MSG_SLOTS        = 3;

  localparam logic [7:0] NOTE_MSG      = 8'h90;
  localparam logic [7:0] CTRL_MSG      = 8'hB0;
  localparam logic [7:0] CTRL_MOD      = 8'h01;
  localparam logic [6:0] MOD_ON        = 7'h7F;
  localparam logic [6:0] MOD_OFF       = 7'h00;
  localparam logic [7:0] OCTAVE_STEP   = 8'h0C;
  localparam logic [8:0] VOLUME_STEP   = 9'h00A;
  localparam logic [7:0] LOW_BASE_RST  = 8'h39;
  localparam logic [7:0] HIGH_BASE_RST = 8'h48;
  localparam logic [7:0] VOLUME_RST    = 8'h40;
  localparam logic [6:0] CEILING_RST   = 7'h7F;
  localparam logic [6:0] FLOOR_RST     = 7'h00;
  localparam logic [3:0] LAST_NOTE_KEY = 4'd14;

  // control row commands, chosen by key index
  localparam logic [3:0] CMD_STEP_UP    = 4'd1;
  localparam logic [3:0] CMD_VOLUME_SEL = 4'd2;
  localparam logic [3:0] CMD_OCTAVE_SEL = 4'd3;
  localparam logic [3:0] CMD_VIBRATO    = 4'd4;
  localparam logic [3:0] CMD_STEP_DOWN  = 4'd5;

  // configuration register indexes
  localparam logic CFG_CEILING = 1'b0;
  localparam logic CFG_FLOOR   = 1'b1;

  typedef struct packed {
    logic [3:0] key_index;
    logic [2:0] row_levels;
  } in_word_t;

  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] data_first;
    logic [6:0] data_second;
    logic       last_message;
  } out_word_t;

  typedef struct packed {
    logic octave;
    logic volume;
    logic vibrato;
  } mode_t;

  // words produced by one sample, packed from slot 0
  typedef struct packed {
    logic [1:0]                      count;
    out_word_t [MSG_SLOTS-1:0]       msg;
  } msg_bundle_t;

  // result buffer status towards the top level
  typedef struct packed {
    logic       can_load;
    logic [1:0] count;
  } buf_status_t;

endpackage

// ===== src/kmng_core.sv =====
// ----------------------------------------------------------------------------
// kmng_core
// key state, base notes, volume, modes and the words one sample produces
// ----------------------------------------------------------------------------
module kmng_core #(
  parameter int KEYS_PER_ROW = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic                  cfg_index,
  input  logic [6:0]            cfg_wdata,
  input  logic                  fire,
  input  kmng_pkg::in_word_t    item,
  output kmng_pkg::msg_bundle_t bundle
);
  import kmng_pkg::*;

  localparam int KIDX_W = $clog2(KEYS_PER_ROW);

  logic [KEYS_PER_ROW-1:0] r1_held_r, r1_held_nxt;
  logic [KEYS_PER_ROW-1:0] r2_held_r, r2_held_nxt;
  logic [KEYS_PER_ROW-1:0] ctl_held_r, ctl_held_nxt;
  logic [7:0]              low_base_r, low_base_nxt;
  logic [7:0]              high_base_r, high_base_nxt;
  logic [7:0]              volume_r, volume_nxt;
  mode_t                   mode_r, mode_nxt;
  logic [6:0]              ceiling_r, floor_r;

  logic                    key_ok;
  logic                    note_key;
  logic [KIDX_W-1:0]       kidx;
  logic [2:0]              cv;
  out_word_t [2:0]         cand;
  logic [1:0]              n;

  assign key_ok   = {1'b0, item.key_index} < 5'(KEYS_PER_ROW);
  assign note_key = item.key_index <= LAST_NOTE_KEY;
  assign kidx     = item.key_index[KIDX_W-1:0];

  always_comb begin
    r1_held_nxt   = r1_held_r;
    r2_held_nxt   = r2_held_r;
    ctl_held_nxt  = ctl_held_r;
    low_base_nxt  = low_base_r;
    high_base_nxt = high_base_r;
    volume_nxt    = volume_r;
    mode_nxt      = mode_r;
    cv            = '0;
    cand          = '0;

    cand[0].status_byte = NOTE_MSG;
    cand[0].data_first  = low_base_r - {4'd0, item.key_index};
    cand[0].data_second = item.row_levels[0] ? volume_r[6:0] : 7'd0;
    cand[1].status_byte = NOTE_MSG;
    cand[1].data_first  = high_base_r - {4'd0, item.key_index};
    cand[1].data_second = item.row_levels[1] ? volume_r[6:0] : 7'd0;
    cand[2].status_byte = CTRL_MSG;
    cand[2].data_first  = CTRL_MOD;
    cand[2].data_second = mode_r.vibrato ? MOD_OFF : MOD_ON;

    if (fire && key_ok) begin
      // note rows: any change of level is an edge
      if (item.row_levels[0] != r1_held_r[kidx]) begin
        r1_held_nxt[kidx] = item.row_levels[0];
        cv[0] = note_key;
      end
      if (item.row_levels[1] != r2_held_r[kidx]) begin
        r2_held_nxt[kidx] = item.row_levels[1];
        cv[1] = note_key;
      end

      // control row commands on rising edge only
      if (item.row_levels[2]) begin
        if (!ctl_held_r[kidx]) begin
          ctl_held_nxt[kidx] = 1'b1;
          unique case (item.key_index)
            CMD_STEP_UP: begin
              if (mode_r.octave) begin
                low_base_nxt  = low_base_r + OCTAVE_STEP;
                high_base_nxt = high_base_r + OCTAVE_STEP;
              end
              if (mode_r.volume) begin
                if ({1'b0, volume_r} + VOLUME_STEP < {2'b00, ceiling_r}) begin
                  volume_nxt = volume_r + VOLUME_STEP[7:0];
                end else begin
                  volume_nxt = {1'b0, ceiling_r};
                end
              end
            end
            CMD_STEP_DOWN: begin
              if (mode_r.octave) begin
                low_base_nxt  = low_base_r - OCTAVE_STEP;
                high_base_nxt = high_base_r - OCTAVE_STEP;
              end
              if (mode_r.volume) begin
                if ({1'b0, volume_r} > {2'b00, floor_r} + VOLUME_STEP) begin
                  volume_nxt = volume_r - VOLUME_STEP[7:0];
                end else begin
                  volume_nxt = {1'b0, floor_r};
                end
              end
            end
            CMD_VOLUME_SEL: begin
              if (!mode_r.octave) mode_nxt.volume = !mode_r.volume;
            end
            CMD_OCTAVE_SEL: begin
              if (!mode_r.volume) mode_nxt.octave = !mode_r.octave;
            end
            CMD_VIBRATO: begin
              mode_nxt.vibrato = !mode_r.vibrato;
              cv[2] = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end else begin
        ctl_held_nxt[kidx] = 1'b0;
      end
    end

    cand[0].last_message = !cv[1] && !cv[2];
    cand[1].last_message = !cv[2];
    cand[2].last_message = 1'b1;
  end

  // pack the live words from slot 0 upwards
  always_comb begin
    n          = 2'd0;
    bundle.msg = '0;
    for (int i = 0; i < MSG_SLOTS; i++) begin
      if (cv[i]) begin
        bundle.msg[n] = cand[i];
        n = n + 2'd1;
      end
    end
    bundle.count = n;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      r1_held_r   <= '0;
      r2_held_r   <= '0;
      ctl_held_r  <= '0;
      low_base_r  <= LOW_BASE_RST;
      high_base_r <= HIGH_BASE_RST;
      volume_r    <= VOLUME_RST;
      mode_r      <= '0;
      ceiling_r   <= CEILING_RST;
      floor_r     <= FLOOR_RST;
    end else begin
      r1_held_r   <= r1_held_nxt;
      r2_held_r   <= r2_held_nxt;
      ctl_held_r  <= ctl_held_nxt;
      low_base_r  <= low_base_nxt;
      high_base_r <= high_base_nxt;
      volume_r    <= volume_nxt;
      mode_r      <= mode_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_CEILING: ceiling_r <= cfg_wdata;
          CFG_FLOOR:   floor_r   <= cfg_wdata;
        endcase
      end
    end
  end

endmodule

// ===== src/kmng_msg_buf.sv =====
// ----------------------------------------------------------------------------
// kmng_msg_buf
// holds the words of one sample and hands them out one a cycle while out_ready is high
// ----------------------------------------------------------------------------
module kmng_msg_buf (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  load,
  input  kmng_pkg::msg_bundle_t bundle,
  input  logic                  out_ready,
  output logic                  out_valid,
  output kmng_pkg::out_word_t   out_data,
  output kmng_pkg::buf_status_t status
);
  import kmng_pkg::*;

  out_word_t [MSG_SLOTS-1:0] msg_r;
  logic [1:0]                cnt_r;
  logic                      pop;

  assign out_valid       = cnt_r != 2'd0;
  assign out_data        = msg_r[0];
  assign pop             = out_valid && out_ready;
  assign status.count    = cnt_r;
  // room when empty or once the last word leaves this cycle
  assign status.can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (load) begin
      cnt_r <= bundle.count;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      msg_r <= bundle.msg;
    end else if (pop) begin
      for (int i = 0; i < MSG_SLOTS - 1; i++) begin
        msg_r[i] <= msg_r[i+1];
      end
    end
  end

endmodule

// ===== src/key_scan_midi_note_generator.sv =====
// ----------------------------------------------------------------------------
// key_scan_midi_note_generator
// turns key scan samples into 3-byte midi note and controller words
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  in_     | input     | in_valid / in_ready    | in_data   (key_index, row_levels)
//  out_    | output    | out_valid / out_ready  | out_data  (status, data, last flag)
//  cfg_    | input     | cfg_we, no wait        | cfg_index, cfg_wdata
//
// a sample sits in the input register, is evaluated once the buffer has room and
// loads 0 to 3 words into the result buffer; the buffer drains one word a cycle
// while out_ready is high, and the next sample is evaluated as its last word leaves
// rst_n is synchronous and clears key state, notes, volume, modes and limits
// a stalled output holds the buffer; only an empty input register still takes a word
// ----------------------------------------------------------------------------
module key_scan_midi_note_generator #(
  parameter int KEYS_PER_ROW = kmng_pkg::KEYS_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  kmng_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output kmng_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata
);
  import kmng_pkg::*;

  in_word_t    in_r;
  logic        in_valid_r;
  logic        fire;
  msg_bundle_t bundle;
  buf_status_t buf_status;

  // evaluate the held sample once the buffer has room for its words
  assign fire     = in_valid_r && buf_status.can_load;
  assign in_ready = !in_valid_r || fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  // payload register, no reset needed
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_r <= in_data;
    end
  end

  kmng_core #(
    .KEYS_PER_ROW (KEYS_PER_ROW)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (in_r),
    .bundle    (bundle)
  );

  kmng_msg_buf u_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (fire),
    .bundle    (bundle),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .status    (buf_status)
  );

  // ---------------------------------------------------------------- checks
`include "key_scan_midi_note_generator_assert.svh"

  // a sample is never evaluated over words still waiting
  `KMNG_ASSERT_SAME(a_fire_room, fire, (buf_status.count == 2'd0) || ((buf_status.count == 2'd1) && out_ready), "sample evaluated while buffer busy")
  // the single word left in the buffer closes its sample
  `KMNG_ASSERT_SAME(a_last_flag, out_valid && (buf_status.count == 2'd1), out_data.last_message, "last word not flagged")
  // a word taken while one is held means the held one moves on
  `KMNG_ASSERT_SAME(a_in_flow, in_valid && in_ready && in_valid_r, fire, "input register overwritten")
  // a loaded bundle shows up on the output next cycle
  `KMNG_ASSERT_NEXT(a_load_show, fire && (bundle.count != 2'd0), out_valid, "loaded words not shown")

endmodule

// ===== sim/key_scan_midi_note_generator_checker.sv =====
// ----------------------------------------------------------------------------
// key_scan_midi_note_generator_checker
// watches the sample, result and register ports, predicts the midi words of
// every accepted sample and compares them in order with the words that leave
// ----------------------------------------------------------------------------
module key_scan_midi_note_generator_checker #(
  parameter int KEYS_PER_ROW = kmng_pkg::KEYS_PER_ROW_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_ready,
  input  kmng_pkg::in_word_t  in_data,
  input  logic                out_valid,
  input  logic                out_ready,
  input  kmng_pkg::out_word_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_index,
  input  logic [6:0]          cfg_wdata,
  output int                  fail_count,
  output int                  words_pending
);
  import kmng_pkg::*;

  logic [15:0] row_one_held;
  logic [15:0] row_two_held;
  logic [15:0] control_held;
  logic [7:0]  low_base;
  logic [7:0]  high_base;
  logic [7:0]  volume;
  mode_t       modes;
  logic [6:0]  vol_ceiling;
  logic [6:0]  vol_floor;

  out_word_t midi_words_due[$];
  int        mismatches = 0;

  function automatic void clear_state();
    row_one_held = '0;
    row_two_held = '0;
    control_held = '0;
    low_base     = LOW_BASE_RST;
    high_base    = HIGH_BASE_RST;
    volume       = VOLUME_RST;
    modes        = '0;
    vol_ceiling  = CEILING_RST;
    vol_floor    = FLOOR_RST;
    midi_words_due.delete();
  endfunction

  function automatic void queue_word(logic [7:0] st, logic [7:0] d1, logic [6:0] d2);
    out_word_t w;
    w.status_byte  = st;
    w.data_first   = d1;
    w.data_second  = d2;
    w.last_message = 1'b0;
    midi_words_due.push_back(w);
  endfunction

  // step up or down: octave moves both bases, volume moves with clamping
  function automatic void apply_step(bit up);
    if (modes.octave) begin
      low_base  = up ? low_base + OCTAVE_STEP : low_base - OCTAVE_STEP;
      high_base = up ? high_base + OCTAVE_STEP : high_base - OCTAVE_STEP;
    end
    if (modes.volume) begin
      if (up) begin
        if (int'(volume) < int'(vol_ceiling) - int'(VOLUME_STEP))
          volume = volume + 8'(VOLUME_STEP);
        else
          volume = {1'b0, vol_ceiling};
      end else begin
        if (int'(volume) > int'(vol_floor) + int'(VOLUME_STEP))
          volume = volume - 8'(VOLUME_STEP);
        else
          volume = {1'b0, vol_floor};
      end
    end
  endfunction

  function automatic void predict_midi_words(in_word_t w);
    logic [3:0] key;
    logic [2:0] lv;
    int         first;
    out_word_t  tail;
    key   = w.key_index;
    lv    = w.row_levels;
    first = midi_words_due.size();
    if (int'(key) < KEYS_PER_ROW) begin
      if (lv[0] != row_one_held[key]) begin
        row_one_held[key] = lv[0];
        if (key <= LAST_NOTE_KEY)
          queue_word(NOTE_MSG, low_base - {4'd0, key}, lv[0] ? volume[6:0] : 7'd0);
      end
      if (lv[1] != row_two_held[key]) begin
        row_two_held[key] = lv[1];
        if (key <= LAST_NOTE_KEY)
          queue_word(NOTE_MSG, high_base - {4'd0, key}, lv[1] ? volume[6:0] : 7'd0);
      end
      if (lv[2]) begin
        if (!control_held[key]) begin
          control_held[key] = 1'b1;
          case (key)
            CMD_STEP_UP:    apply_step(1'b1);
            CMD_STEP_DOWN:  apply_step(1'b0);
            CMD_VOLUME_SEL: if (!modes.octave) modes.volume = ~modes.volume;
            CMD_OCTAVE_SEL: if (!modes.volume) modes.octave = ~modes.octave;
            CMD_VIBRATO: begin
              modes.vibrato = ~modes.vibrato;
              queue_word(CTRL_MSG, CTRL_MOD, modes.vibrato ? MOD_ON : MOD_OFF);
            end
            default: ;
          endcase
        end
      end else begin
        control_held[key] = 1'b0;
      end
      if (midi_words_due.size() > first) begin
        tail = midi_words_due.pop_back();
        tail.last_message = 1'b1;
        midi_words_due.push_back(tail);
      end
    end
  endfunction

  function automatic void compare_word(out_word_t got);
    out_word_t want;
    if (midi_words_due.size() == 0) begin
      $error("unexpected word %h with none pending", got);
      mismatches++;
      return;
    end
    want = midi_words_due.pop_front();
    if (got.status_byte !== want.status_byte) begin
      $error("status_byte expected %h got %h", want.status_byte, got.status_byte);
      mismatches++;
    end
    if (got.data_first !== want.data_first) begin
      $error("data_first expected %h got %h", want.data_first, got.data_first);
      mismatches++;
    end
    if (got.data_second !== want.data_second) begin
      $error("data_second expected %h got %h", want.data_second, got.data_second);
      mismatches++;
    end
    if (got.last_message !== want.last_message) begin
      $error("last_message expected %b got %b", want.last_message, got.last_message);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_CEILING) vol_ceiling = cfg_wdata;
        else vol_floor = cfg_wdata;
      end
      // a word leaving now never belongs to a sample taken at this edge
      if (out_valid && out_ready) compare_word(out_data);
      if (in_valid && in_ready) predict_midi_words(in_data);
    end
    fail_count    <= mismatches;
    words_pending <= midi_words_due.size();
  end

endmodule

// ===== sim/key_scan_midi_note_generator_tb.sv =====
// ----------------------------------------------------------------------------
// key_scan_midi_note_generator_tb
// drives scan samples and limit writes into the note generator, stalls both
// channels at random and leaves prediction and comparison to the checker
// ----------------------------------------------------------------------------
module key_scan_midi_note_generator_tb;
  import kmng_pkg::*;

  // watchdog limit on the length of the whole run
  localparam int CYCLE_LIMIT   = 400000;
  // cycles for a sample that makes no word to clear the block
  localparam int SETTLE_CYCLES = 8;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  in_word_t   in_data   = '0;
  logic       in_ready;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_word_t  out_data;
  logic       cfg_we    = 1'b0;
  logic       cfg_index = CFG_CEILING;
  logic [6:0] cfg_wdata = '0;

  int   fail_count;
  int   words_pending;
  logic steady      = 1'b0;
  int   ready_hold  = 0;
  int   cycle_count = 0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  key_scan_midi_note_generator i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  key_scan_midi_note_generator_checker i_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .words_pending (words_pending)
  );

  // gap length: mostly none or short, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady) return 0;
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // result side back-pressure, held for a random stretch each time
  always @(posedge clk) begin
    if (ready_hold > 0) begin
      ready_hold <= ready_hold - 1;
    end else begin
      out_ready  <= steady || ($urandom_range(0, 3) != 0);
      ready_hold <= idle_len();
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("key_scan_midi_note_generator_tb: FAIL");
      $finish;
    end
  end

  // one sample word; valid stays up through a zero gap so back-to-back
  // words never see a low pulse in between
  task automatic send_sample(input logic [3:0] key, input logic [2:0] rows);
    int gap;
    in_valid <= 1'b1;
    in_data  <= {key, rows};
    do @(posedge clk); while (!in_ready);
    gap = idle_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // hold off until every predicted word has left, then let the block settle
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // volume clamps, written back to back while the block is idle
  task automatic set_limits(input logic [6:0] ceiling, input logic [6:0] floor_lvl);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_CEILING;
    cfg_wdata <= ceiling;
    @(posedge clk);
    cfg_index <= CFG_FLOOR;
    cfg_wdata <= floor_lvl;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // random phase: mostly control presses and note play, some raw noise
  task automatic random_phase(input int count);
    int         sent;
    int         r;
    logic [3:0] key;
    logic [1:0] notes;
    sent = 0;
    while (sent < count) begin
      r     = $urandom_range(0, 99);
      notes = 2'($urandom_range(0, 3));
      if (r < 25) begin
        // press and release of a control key, mostly the command columns
        key = ($urandom_range(0, 4) != 0) ? 4'($urandom_range(1, 5))
                                          : 4'($urandom_range(0, 15));
        send_sample(key, {1'b1, notes});
        send_sample(key, {1'b0, 2'($urandom_range(0, 3))});
        sent += 2;
      end else if (r < 85) begin
        // note play, control row only rarely
        key = 4'($urandom_range(0, 15));
        send_sample(key, {($urandom_range(0, 7) == 0), notes});
        sent++;
      end else begin
        send_sample(4'($urandom), 3'($urandom));
        sent++;
      end
      // now and then wait for the result side to empty mid phase
      if ($urandom_range(0, 59) == 0) drain();
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    set_limits(7'd127, 7'd0);

    // both note rows at the lowest and highest note columns
    send_sample(4'd0, 3'b011);
    send_sample(4'd0, 3'b000);
    send_sample(4'd14, 3'b011);
    send_sample(4'd14, 3'b001);
    send_sample(4'd14, 3'b000);
    // last column keeps state but sends nothing
    send_sample(4'd15, 3'b111);
    send_sample(4'd15, 3'b000);
    // vibrato on, then notes, then both notes off with vibrato off: 3 words
    send_sample(CMD_VIBRATO, 3'b100);
    send_sample(CMD_VIBRATO, 3'b011);
    send_sample(CMD_VIBRATO, 3'b100);
    send_sample(CMD_VIBRATO, 3'b000);
    // volume mode on, octave toggle refused while it is on, then volume steps up and down
    send_sample(CMD_VOLUME_SEL, 3'b100);
    send_sample(CMD_VOLUME_SEL, 3'b000);
    send_sample(CMD_OCTAVE_SEL, 3'b100);
    send_sample(CMD_OCTAVE_SEL, 3'b000);
    send_sample(CMD_STEP_UP, 3'b100);
    send_sample(CMD_STEP_UP, 3'b011);
    send_sample(CMD_STEP_DOWN, 3'b100);
    send_sample(CMD_STEP_DOWN, 3'b000);
    // swap to octave mode and move the bases
    send_sample(CMD_VOLUME_SEL, 3'b100);
    send_sample(CMD_VOLUME_SEL, 3'b000);
    send_sample(CMD_OCTAVE_SEL, 3'b100);
    send_sample(CMD_OCTAVE_SEL, 3'b000);
    send_sample(CMD_STEP_UP, 3'b100);
    send_sample(4'd7, 3'b111);
    send_sample(4'd7, 3'b000);

    // full-rate phase, no stalls on either side
    drain();
    steady <= 1'b1;
    random_phase(110);
    drain();
    steady <= 1'b0;

    // floor above ceiling
    set_limits(7'd0, 7'd127);
    random_phase(110);
    drain();

    set_limits(7'd100, 7'd20);
    random_phase(110);
    drain();

    set_limits(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    random_phase(110);
    drain();

    repeat (20) @(posedge clk);
    if (fail_count == 0)
      $display("key_scan_midi_note_generator_tb: PASS");
    else
      $display("key_scan_midi_note_generator_tb: FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+src
src/kmng_pkg.sv
src/kmng_core.sv
src/kmng_msg_buf.sv
src/key_scan_midi_note_generator.sv
sim/key_scan_midi_note_generator_checker.sv
sim/key_scan_midi_note_generator_tb.sv
